[hdl/pcc_pkg.sv]
package pcc_pkg;

    // Table size used when the top level is not given another.
    localparam int NUM_PLANES_DEF = 64;

    // Field widths of one input word and one result word.
    localparam int INDEX_W = 6;
    localparam int VEC_W   = 32;
    localparam int NORM_W  = 16;
    localparam int CAM_W   = 9;

    // Arithmetic widths: a Q15.16 by Q1.14 product, the sum of three, the distance.
    localparam int PROD_W  = VEC_W + NORM_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int DIST_W  = 50;
    localparam int FRAC_SHIFT = 14;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_BITS      = INDEX_W + 4 * VEC_W + 3 * CAM_W + 1;
    localparam int TDATA_IN_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_W  = ((CAM_W + 7) / 8) * 8;

    // Operation carried in tuser.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_DECIDE,
        ST_DONE
    } state_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

    // One input word, unpacked.
    typedef struct packed {
        op_t                       op;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VEC_W-1:0]   vec_x;
        logic signed [VEC_W-1:0]   vec_y;
        logic signed [VEC_W-1:0]   vec_z;
        logic signed [VEC_W-1:0]   plane_offset;
        logic signed [CAM_W-1:0]   front_camera;
        logic signed [CAM_W-1:0]   back_camera;
        logic                      entry_enabled;
        logic signed [CAM_W-1:0]   current_camera;
    } item_t;

    // Plane geometry and cameras, loaded by a write word.
    typedef struct packed {
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic signed [VEC_W-1:0]   offset;
        logic signed [CAM_W-1:0]   front;
        logic signed [CAM_W-1:0]   back;
    } entry_t;

    // Per-plane tracking state, cleared after reset.
    typedef struct packed {
        logic                      enabled;
        logic                      seen;
        logic signed [DIST_W-1:0]  distance;
    } track_t;

    // Controls of the multiply-accumulate unit.
    typedef struct packed {
        logic mul;
        sel_t sel;
        logic clear;
        logic add;
    } mac_ctl_t;

endpackage

[hdl/plane_crossing_camera_select.sv]
// Channel   Dir  Bits  Word contents
// s_*       in   168   one write or evaluate word, operation in s_tuser
// m_*       out  16    active camera of one evaluation
//
// A write word is taken in the idle state and gives no result. An
// evaluate word walks every entry with one shared multiplier: a disabled
// entry is read and skipped; an enabled one is read, multiplied three times,
// summed with a final add and decided. A done state then offers the result.
// After reset the tracking memory is cleared entry by entry, with s_tready
// low. A result held by a stalled m_tready does not block the next
// word; only a second result waits for the output register to drain.
module plane_crossing_camera_select #(
    parameter int NUM_PLANES = pcc_pkg::NUM_PLANES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index, vec_x, vec_y, vec_z, plane_offset, front_camera,
    // back_camera, entry_enabled, current_camera, zero fill
    input  logic [pcc_pkg::TDATA_IN_W-1:0]      s_tdata,
    // operation
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // active_camera, zero fill
    output logic [pcc_pkg::TDATA_OUT_W-1:0]     m_tdata
);

    localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    pcc_pkg::item_t                     item;
    logic                               ent_we;
    logic [IDX_W-1:0]                   ent_waddr;
    pcc_pkg::entry_t                    ent_wdata;
    logic                               trk_we;
    logic [IDX_W-1:0]                   trk_waddr;
    pcc_pkg::track_t                    trk_wdata;
    logic [IDX_W-1:0]                   rd_addr;
    pcc_pkg::entry_t                    ent_rdata;
    pcc_pkg::track_t                    trk_rdata;
    pcc_pkg::mac_ctl_t                  mac_ctl;
    logic signed [pcc_pkg::VEC_W-1:0]   pos_x, pos_y, pos_z;
    logic signed [pcc_pkg::DIST_W-1:0]  distance;
    logic                               res_valid;
    logic                               res_ready;
    logic signed [pcc_pkg::CAM_W-1:0]   res_cam;
    logic                               out_valid_reg, out_valid_next;
    logic signed [pcc_pkg::CAM_W-1:0]   out_cam_reg;

    // Unpack the input word.
    assign item.op             = pcc_pkg::op_t'(s_tuser);
    assign item.entry_index    = s_tdata[5:0];
    assign item.vec_x          = s_tdata[37:6];
    assign item.vec_y          = s_tdata[69:38];
    assign item.vec_z          = s_tdata[101:70];
    assign item.plane_offset   = s_tdata[133:102];
    assign item.front_camera   = s_tdata[142:134];
    assign item.back_camera    = s_tdata[151:143];
    assign item.entry_enabled  = s_tdata[152];
    assign item.current_camera = s_tdata[161:153];

    pcc_ctrl #(
        .NUM_PLANES (NUM_PLANES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .trk_we    (trk_we),
        .trk_waddr (trk_waddr),
        .trk_wdata (trk_wdata),
        .rd_addr   (rd_addr),
        .ent_rdata (ent_rdata),
        .trk_rdata (trk_rdata),
        .mac_ctl   (mac_ctl),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .distance  (distance),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_cam   (res_cam)
    );

    pcc_table #(
        .NUM_PLANES (NUM_PLANES)
    ) u_table (
        .clk       (clk),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .trk_we    (trk_we),
        .trk_waddr (trk_waddr),
        .trk_wdata (trk_wdata),
        .rd_addr   (rd_addr),
        .ent_rdata (ent_rdata),
        .trk_rdata (trk_rdata)
    );

    pcc_mac u_mac (
        .clk      (clk),
        .ctl      (mac_ctl),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .entry    (ent_rdata),
        .distance (distance)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_cam_reg <= res_cam;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pcc_pkg::TDATA_OUT_W'(unsigned'(out_cam_reg));

endmodule

[hdl/pcc_table.sv]
module pcc_table #(
    parameter int NUM_PLANES = pcc_pkg::NUM_PLANES_DEF,
    localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
    input  logic                  clk,
    input  logic                  ent_we,
    input  logic [IDX_W-1:0]      ent_waddr,
    input  pcc_pkg::entry_t       ent_wdata,
    input  logic                  trk_we,
    input  logic [IDX_W-1:0]      trk_waddr,
    input  pcc_pkg::track_t       trk_wdata,
    input  logic [IDX_W-1:0]      rd_addr,
    output pcc_pkg::entry_t       ent_rdata,
    output pcc_pkg::track_t       trk_rdata
);

    pcc_pkg::entry_t entry_mem [NUM_PLANES];
    pcc_pkg::track_t track_mem [NUM_PLANES];

    // Plane geometry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata <= entry_mem[rd_addr];
    end

    // Tracking memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (trk_we)
        begin
            track_mem[trk_waddr] <= trk_wdata;
        end
        trk_rdata <= track_mem[rd_addr];
    end

endmodule

[hdl/pcc_mac.sv]
module pcc_mac (
    input  logic                                   clk,
    input  pcc_pkg::mac_ctl_t                      ctl,
    input  logic signed [pcc_pkg::VEC_W-1:0]       pos_x,
    input  logic signed [pcc_pkg::VEC_W-1:0]       pos_y,
    input  logic signed [pcc_pkg::VEC_W-1:0]       pos_z,
    input  pcc_pkg::entry_t                        entry,
    output logic signed [pcc_pkg::DIST_W-1:0]      distance
);

    logic signed [pcc_pkg::VEC_W-1:0]   op_a;
    logic signed [pcc_pkg::NORM_W-1:0]  op_b;
    logic signed [pcc_pkg::PROD_W-1:0]  prod_reg;
    logic signed [pcc_pkg::PROD_W-1:0]  prod_next;
    logic signed [pcc_pkg::ACC_W-1:0]   acc_reg;
    logic signed [pcc_pkg::ACC_W-1:0]   acc_next;
    logic signed [pcc_pkg::ACC_W-1:0]   acc_base;
    logic signed [pcc_pkg::ACC_W-1:0]   acc_floor;

    // Operand selection for the single multiplier.
    always_comb
    begin
        unique case (ctl.sel)
            pcc_pkg::SEL_X:
            begin
                op_a = pos_x;
                op_b = entry.nx;
            end
            pcc_pkg::SEL_Y:
            begin
                op_a = pos_y;
                op_b = entry.ny;
            end
            pcc_pkg::SEL_Z:
            begin
                op_a = pos_z;
                op_b = entry.nz;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The product is exact in 48 bits; the three-term sum is exact in 50.
    assign prod_next = op_a * op_b;
    assign acc_base  = ctl.clear ? '0 : acc_reg;
    assign acc_next  = acc_base + pcc_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.add)
        begin
            acc_reg <= acc_next;
        end
    end

    // Arithmetic shift floors the Q.30 sum to Q.16, then the offset comes off.
    assign acc_floor = acc_reg >>> pcc_pkg::FRAC_SHIFT;
    assign distance = pcc_pkg::DIST_W'(acc_floor) - pcc_pkg::DIST_W'(entry.offset);

endmodule

[hdl/pcc_ctrl.sv]
module pcc_ctrl #(
    parameter int NUM_PLANES = pcc_pkg::NUM_PLANES_DEF,
    localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pcc_pkg::item_t                      item,
    output logic                                ent_we,
    output logic [IDX_W-1:0]                    ent_waddr,
    output pcc_pkg::entry_t                     ent_wdata,
    output logic                                trk_we,
    output logic [IDX_W-1:0]                    trk_waddr,
    output pcc_pkg::track_t                     trk_wdata,
    output logic [IDX_W-1:0]                    rd_addr,
    input  pcc_pkg::entry_t                     ent_rdata,
    input  pcc_pkg::track_t                     trk_rdata,
    output pcc_pkg::mac_ctl_t                   mac_ctl,
    output logic signed [pcc_pkg::VEC_W-1:0]    pos_x,
    output logic signed [pcc_pkg::VEC_W-1:0]    pos_y,
    output logic signed [pcc_pkg::VEC_W-1:0]    pos_z,
    input  logic signed [pcc_pkg::DIST_W-1:0]   distance,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [pcc_pkg::CAM_W-1:0]    res_cam
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PLANES - 1);

    pcc_pkg::state_t                    state_reg, state_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    pcc_pkg::sel_t                      step_reg, step_next;
    logic signed [pcc_pkg::VEC_W-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [pcc_pkg::CAM_W-1:0]   cam_reg, cam_next;
    logic                               accept;
    logic                               in_range;
    logic                               last_idx;
    logic                               rise;
    logic                               fall;

    assign accept   = in_valid && in_ready;
    assign in_range = 32'(item.entry_index) < 32'(NUM_PLANES);
    assign last_idx = (idx_reg == LAST_IDX);

    // Crossing tests against the distance stored at the last evaluation.
    assign rise = trk_rdata.distance[pcc_pkg::DIST_W-1] && !distance[pcc_pkg::DIST_W-1];
    assign fall = !trk_rdata.distance[pcc_pkg::DIST_W-1] && (trk_rdata.distance != '0)
                  && (distance[pcc_pkg::DIST_W-1] || (distance == '0));

    assign pos_x   = pos_x_reg;
    assign pos_y   = pos_y_reg;
    assign pos_z   = pos_z_reg;
    assign res_cam = cam_reg;
    assign rd_addr = idx_reg;

    // Write words load the entry straight from the input word.
    assign ent_waddr       = IDX_W'(item.entry_index);
    assign ent_wdata.nx    = item.vec_x[pcc_pkg::NORM_W-1:0];
    assign ent_wdata.ny    = item.vec_y[pcc_pkg::NORM_W-1:0];
    assign ent_wdata.nz    = item.vec_z[pcc_pkg::NORM_W-1:0];
    assign ent_wdata.offset = item.plane_offset;
    assign ent_wdata.front = item.front_camera;
    assign ent_wdata.back  = item.back_camera;

    // State and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcc_pkg::ST_CLEAR;
            idx_reg   <= '0;
            step_reg  <= pcc_pkg::SEL_X;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    // Position and camera of the evaluation in progress.
    always_ff @(posedge clk)
    begin
        if (accept && (item.op == pcc_pkg::OP_EVAL))
        begin
            pos_x_reg <= item.vec_x;
            pos_y_reg <= item.vec_y;
            pos_z_reg <= item.vec_z;
        end
        cam_reg <= cam_next;
    end

    // Sequencer: next state and controls.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cam_next   = cam_reg;
        in_ready   = 1'b0;
        ent_we     = 1'b0;
        trk_we     = 1'b0;
        trk_waddr  = idx_reg;
        trk_wdata  = '0;
        mac_ctl    = '{mul: 1'b0, sel: step_reg, clear: 1'b0, add: 1'b0};
        res_valid  = 1'b0;

        unique case (state_reg)
            pcc_pkg::ST_CLEAR:
            begin
                // Sweep the tracking memory to disabled, one entry a cycle.
                trk_we = 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = pcc_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pcc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (item.op == pcc_pkg::OP_EVAL)
                    begin
                        cam_next   = item.current_camera;
                        idx_next   = '0;
                        state_next = pcc_pkg::ST_READ;
                    end
                    else if (in_range)
                    begin
                        ent_we            = 1'b1;
                        trk_we            = 1'b1;
                        trk_waddr         = IDX_W'(item.entry_index);
                        trk_wdata.enabled = item.entry_enabled;
                    end
                end
            end
            pcc_pkg::ST_READ:
            begin
                step_next  = pcc_pkg::SEL_X;
                state_next = pcc_pkg::ST_MUL;
            end
            pcc_pkg::ST_MUL:
            begin
                mac_ctl.mul = 1'b1;
                unique case (step_reg)
                    pcc_pkg::SEL_X:
                    begin
                        mac_ctl.mul = trk_rdata.enabled;
                        if (!trk_rdata.enabled)
                        begin
                            if (last_idx)
                            begin
                                state_next = pcc_pkg::ST_DONE;
                            end
                            else
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = pcc_pkg::ST_READ;
                            end
                        end
                        else
                        begin
                            step_next = pcc_pkg::SEL_Y;
                        end
                    end
                    pcc_pkg::SEL_Y:
                    begin
                        mac_ctl.clear = 1'b1;
                        mac_ctl.add   = 1'b1;
                        step_next     = pcc_pkg::SEL_Z;
                    end
                    default:
                    begin
                        mac_ctl.add = 1'b1;
                        state_next  = pcc_pkg::ST_ACC;
                    end
                endcase
            end
            pcc_pkg::ST_ACC:
            begin
                mac_ctl.add = 1'b1;
                state_next  = pcc_pkg::ST_DECIDE;
            end
            pcc_pkg::ST_DECIDE:
            begin
                // Apply a crossing, then store this distance for the next frame.
                if (trk_rdata.seen)
                begin
                    if (rise)
                    begin
                        if (!ent_rdata.front[pcc_pkg::CAM_W-1])
                        begin
                            cam_next = ent_rdata.front;
                        end
                    end
                    else if (fall)
                    begin
                        if (!ent_rdata.back[pcc_pkg::CAM_W-1])
                        begin
                            cam_next = ent_rdata.back;
                        end
                    end
                end
                trk_we             = 1'b1;
                trk_wdata.enabled  = 1'b1;
                trk_wdata.seen     = 1'b1;
                trk_wdata.distance = distance;
                if (last_idx)
                begin
                    state_next = pcc_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = pcc_pkg::ST_READ;
                end
            end
            pcc_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    idx_next   = '0;
                    state_next = pcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The tracking memory is written only while clearing, on a write word or on a decision.
    assert property (@(posedge clk) disable iff (!rst_n)
        trk_we |-> (state_reg == pcc_pkg::ST_CLEAR || state_reg == pcc_pkg::ST_IDLE
                    || state_reg == pcc_pkg::ST_DECIDE))
        else $error("tracking write outside clear, idle or decide");

    // The clearing sweep runs to the last entry before anything is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcc_pkg::ST_CLEAR && !last_idx) |=> (state_reg == pcc_pkg::ST_CLEAR))
        else $error("clearing sweep left early");

    // A decision always follows the final accumulate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcc_pkg::ST_DECIDE) |-> ($past(state_reg) == pcc_pkg::ST_ACC))
        else $error("decision without a finished dot product");

    // A waiting result keeps its camera until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(cam_reg)))
        else $error("pending result changed");
`endif

endmodule
